@@ design/hll_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and tables of the hyperloglog distinct counter
package hll_pkg;

  localparam int MAX_LOG2_COUNTERS_DEF = 14;
  localparam int MIN_LOG2_COUNTERS     = 4;
  localparam logic [3:0] LOG2_COUNTERS_RST = 4'd14;

  localparam logic [6:0] MAX_RANK     = 7'd65;
  localparam int         HASH_IDX_LSB = 44;
  localparam logic [6:0] Z_FRAC_BITS  = 7'd70;
  localparam int         NUM_SHIFT    = 40;
  localparam int         LOG_ITERS    = 32;
  localparam int         LN2_BITS     = 26;
  localparam logic [LN2_BITS-1:0] LN2_Q26 = 26'd46516320;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_MERGE    = 2'd1,
    REQ_ESTIMATE = 2'd2,
    REQ_CLEAR    = 2'd3
  } hll_req_t;

  // bias constant alpha in q30, indexed by log2 of the counter count
  localparam logic [29:0] ALPHA_Q30 [0:20] = '{
    30'd0, 30'd0, 30'd0, 30'd0,
    30'(((64'd673 << 30) + 64'd500) / 64'd1000),
    30'(((64'd697 << 30) + 64'd500) / 64'd1000),
    30'(((64'd709 << 30) + 64'd500) / 64'd1000),
    30'(((64'd7213 << 37) + (64'd5000 << 7) + 64'd5395) / ((64'd10000 << 7) + 64'd10790)),
    30'(((64'd7213 << 38) + (64'd5000 << 8) + 64'd5395) / ((64'd10000 << 8) + 64'd10790)),
    30'(((64'd7213 << 39) + (64'd5000 << 9) + 64'd5395) / ((64'd10000 << 9) + 64'd10790)),
    30'(((64'd7213 << 40) + (64'd5000 << 10) + 64'd5395) / ((64'd10000 << 10) + 64'd10790)),
    30'(((64'd7213 << 41) + (64'd5000 << 11) + 64'd5395) / ((64'd10000 << 11) + 64'd10790)),
    30'(((64'd7213 << 42) + (64'd5000 << 12) + 64'd5395) / ((64'd10000 << 12) + 64'd10790)),
    30'(((64'd7213 << 43) + (64'd5000 << 13) + 64'd5395) / ((64'd10000 << 13) + 64'd10790)),
    30'(((64'd7213 << 44) + (64'd5000 << 14) + 64'd5395) / ((64'd10000 << 14) + 64'd10790)),
    30'(((64'd7213 << 45) + (64'd5000 << 15) + 64'd5395) / ((64'd10000 << 15) + 64'd10790)),
    30'(((64'd7213 << 46) + (64'd5000 << 16) + 64'd5395) / ((64'd10000 << 16) + 64'd10790)),
    30'(((64'd7213 << 47) + (64'd5000 << 17) + 64'd5395) / ((64'd10000 << 17) + 64'd10790)),
    30'(((64'd7213 << 48) + (64'd5000 << 18) + 64'd5395) / ((64'd10000 << 18) + 64'd10790)),
    30'(((64'd7213 << 49) + (64'd5000 << 19) + 64'd5395) / ((64'd10000 << 19) + 64'd10790)),
    30'(((64'd7213 << 50) + (64'd5000 << 20) + 64'd5395) / ((64'd10000 << 20) + 64'd10790))
  };

  typedef struct packed {
    logic ins_load;
    logic ins_write;
    logic clr_start;
    logic clr_step;
    logic sum_start;
    logic sum_step;
    logic div_load;
    logic div_step;
    logic log_load;
    logic log_step;
    logic ln_mul;
    logic fin;
    logic fin_lin;
  } hll_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sum_last;
    logic div_last;
    logic log_last;
    logic lin_needed;
    logic out_free;
  } hll_status_t;

endpackage

@@ design/hll_if.sv @@
`timescale 1ns / 1ps
// channel interfaces of the hyperloglog distinct counter
interface hll_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] hash_value;
  logic [19:0] merge_index;
  logic [6:0]  merge_value;
  modport source (output valid, req_type, hash_value, merge_index, merge_value, input ready);
  modport sink (input valid, req_type, hash_value, merge_index, merge_value, output ready);
endinterface

interface hll_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] estimate;
  logic        used_linear_counting;
  modport source (output valid, estimate, used_linear_counting, input ready);
  modport sink (input valid, estimate, used_linear_counting, output ready);
endinterface

interface hll_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] log2_counters;
  modport source (output valid, log2_counters, input ready);
  modport sink (input valid, log2_counters, output ready);
endinterface

@@ design/hyperloglog_distinct_counter.sv @@
`timescale 1ns / 1ps
// top level of the hyperloglog distinct counter
//
// HyperLogLog sketch of 2^k seven-bit rank counters (k from cfg, clamped to
// 4..MAX_LOG2_COUNTERS) held in one memory with a read and a write port. One
// transaction is worked at a time. Insert and merge read the counter, then
// write it if the new rank is larger. Clear sweeps the whole memory, one entry
// a cycle; the same clearing pass runs right after reset and in_chan.ready
// stays low meanwhile, while cfg writes are taken at any time. Estimate walks
// the m active counters, runs a bit-serial restoring divide, then a check
// state and a result state; when linear counting applies, a 32-step squaring
// log and a multiply state sit between those two. The result state waits
// while out_chan still holds an earlier estimate. Results sit in an output
// register, so a new transaction is taken while an estimate still waits on
// out_chan.
module hyperloglog_distinct_counter #(
  parameter int MAX_LOG2_COUNTERS = hll_pkg::MAX_LOG2_COUNTERS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hll_req_if.sink   in_chan,
  hll_res_if.source out_chan,
  hll_cfg_if.sink   cfg_chan
);

  hll_pkg::hll_cmd_t    cmd;
  hll_pkg::hll_status_t status;

  // cfg is a single register, always writable
  assign cfg_chan.ready = 1'b1;

  hll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .req_type (in_chan.req_type),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hll_datapath #(
    .MAX_LOG2_COUNTERS (MAX_LOG2_COUNTERS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .req_type    (in_chan.req_type),
    .hash_value  (in_chan.hash_value),
    .merge_index (in_chan.merge_index),
    .merge_value (in_chan.merge_value),
    .cfg_we      (cfg_chan.valid),
    .cfg_data    (cfg_chan.log2_counters),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_est     (out_chan.estimate),
    .out_lin     (out_chan.used_linear_counting)
  );

  // an insert or merge transaction holds off the next one for its write cycle
  a_ins_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready &&
     (in_chan.req_type == hll_pkg::REQ_INSERT || in_chan.req_type == hll_pkg::REQ_MERGE))
    |=> !in_chan.ready)
    else $error("insert/merge did not block the input");

  // a clear transaction starts a sweep
  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.req_type == hll_pkg::REQ_CLEAR)
    |=> !in_chan.ready)
    else $error("clear did not block the input");

  // linear counting results are small: m * ln(m) stays far below 2^32
  a_lin_small: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.used_linear_counting) |-> (out_chan.estimate[63:32] == 32'd0))
    else $error("linear counting estimate out of range");

  // an estimate cannot come out in the cycle right after its request
  a_est_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.req_type == hll_pkg::REQ_ESTIMATE)
    |=> !$rose(out_chan.valid))
    else $error("estimate finished too early");

endmodule

@@ design/hll_datapath.sv @@
`timescale 1ns / 1ps
// counter store, harmonic sum, divider, log unit and result register
module hll_datapath #(
  parameter int MAX_LOG2_COUNTERS = hll_pkg::MAX_LOG2_COUNTERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hll_pkg::hll_cmd_t   cmd,
  output hll_pkg::hll_status_t status,
  input  logic [1:0]          req_type,
  input  logic [63:0]         hash_value,
  input  logic [19:0]         merge_index,
  input  logic [6:0]          merge_value,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [63:0]         out_est,
  output logic                out_lin
);

  localparam int AW    = MAX_LOG2_COUNTERS;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(MAX_LOG2_COUNTERS + 1);
  localparam int VW    = AW + 1;
  localparam int ZW    = 71 + AW;
  localparam int NW    = 70 + 2 * AW;
  localparam int DCW   = $clog2(NW);
  localparam int DW    = KW + 32;
  localparam int PRW   = DW + hll_pkg::LN2_BITS;

  // configuration and effective k
  logic [3:0]    k_cfg_r;
  logic [KW-1:0] keff;
  logic [AW-1:0] mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r <= hll_pkg::LOG2_COUNTERS_RST;
    end else if (cfg_we) begin
      k_cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (int'(k_cfg_r) < hll_pkg::MIN_LOG2_COUNTERS) begin
      keff = KW'(hll_pkg::MIN_LOG2_COUNTERS);
    end else if (int'(k_cfg_r) > MAX_LOG2_COUNTERS) begin
      keff = KW'(MAX_LOG2_COUNTERS);
    end else begin
      keff = KW'(k_cfg_r);
    end
  end

  assign mask = ~({AW{1'b1}} << keff);

  // rank of an insert or merge item
  logic [6:0]    in_rank;
  logic [AW-1:0] in_idx;

  always_comb begin
    logic [6:0] tz;
    tz = 7'd0;
    for (int i = 63; i >= 0; i--) begin
      if (hash_value[i]) tz = 7'(i);
    end
    if (hll_pkg::hll_req_t'(req_type) == hll_pkg::REQ_MERGE) begin
      in_rank = (merge_value > hll_pkg::MAX_RANK) ? hll_pkg::MAX_RANK : merge_value;
      in_idx  = merge_index[AW-1:0] & mask;
    end else begin
      in_rank = (hash_value == 64'd0) ? hll_pkg::MAX_RANK : tz + 7'd1;
      in_idx  = hash_value[hll_pkg::HASH_IDX_LSB +: AW] & mask;
    end
  end

  // counter memory
  logic [6:0]    mem [DEPTH];
  logic [6:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [6:0]    wr_data;
  logic          wr_en;
  logic [AW-1:0] idx_r;
  logic [6:0]    rank_r;
  logic [AW-1:0] scan_cnt_r;

  assign rd_addr = cmd.sum_step ? scan_cnt_r : in_idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rank_r;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = scan_cnt_r;
      wr_data = 7'd0;
    end else if (cmd.ins_write && (rank_r > rd_data_r)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_load) begin
      idx_r  <= in_idx;
      rank_r <= in_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (cmd.clr_start || cmd.sum_start) begin
      scan_cnt_r <= '0;
    end else if (cmd.clr_step || cmd.sum_step) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  // harmonic sum, one counter a cycle
  logic          pend_r;
  logic [ZW-1:0] z_r;
  logic [VW-1:0] zeros_r;
  logic [6:0]    c_clamp;

  assign c_clamp = (rd_data_r > hll_pkg::MAX_RANK) ? hll_pkg::MAX_RANK : rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.sum_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      z_r     <= '0;
      zeros_r <= '0;
    end else if (pend_r) begin
      z_r <= z_r + (ZW'(1) << (hll_pkg::Z_FRAC_BITS - c_clamp));
      if (c_clamp == 7'd0) begin
        zeros_r <= zeros_r + 1'b1;
      end
    end
  end

  // restoring divider, quotient shifts into the numerator register
  logic [ZW-1:0]  rem_r;
  logic [NW-1:0]  num_r;
  logic [DCW-1:0] dcnt_r;
  logic [ZW:0]    rem_sh;
  logic           ge;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, z_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= '0;
      num_r  <= NW'(hll_pkg::ALPHA_Q30[5'(keff)]) << (2 * int'(keff) + hll_pkg::NUM_SHIFT);
      dcnt_r <= DCW'(NW - 1);
    end else if (cmd.div_step) begin
      rem_r  <= ge ? ZW'(rem_sh - {1'b0, z_r}) : rem_sh[ZW-1:0];
      num_r  <= {num_r[NW-2:0], ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  logic        q_sat;
  logic [63:0] q_lo;
  logic [63:0] lin_thr;

  assign q_sat   = |num_r[NW-1:64];
  assign q_lo    = num_r[63:0];
  assign lin_thr = (64'd5 << keff) >> 1;

  // log2 of the zero count: integer part by top bit, fraction by squaring
  logic [KW-1:0] top_p;
  logic [30:0]   y0;
  logic [30:0]   y_r;
  logic [KW-1:0] p_r;
  logic [31:0]   frac_r;
  logic [4:0]    lcnt_r;
  logic [61:0]   sq;
  logic [31:0]   sq_t;

  always_comb begin
    top_p = '0;
    for (int i = 0; i < VW; i++) begin
      if (zeros_r[i]) top_p = KW'(i);
    end
  end

  assign y0   = 31'({zeros_r, 30'd0} >> top_p);
  assign sq   = 62'(y_r) * 62'(y_r);
  assign sq_t = sq[61:30];

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      y_r    <= y0;
      p_r    <= top_p;
      frac_r <= '0;
      lcnt_r <= 5'(hll_pkg::LOG_ITERS - 1);
    end else if (cmd.log_step) begin
      if (sq_t[31]) begin
        y_r    <= sq_t[31:1];
        frac_r <= {frac_r[30:0], 1'b1};
      end else begin
        y_r    <= sq_t[30:0];
        frac_r <= {frac_r[30:0], 1'b0};
      end
      lcnt_r <= lcnt_r - 1'b1;
    end
  end

  // natural log and scale by m
  logic [DW-1:0]  d_val;
  logic [PRW-1:0] prod_r;
  logic [DW-1:0]  ln_val;
  logic [63:0]    est_lin;

  assign d_val  = {keff, 32'd0} - {p_r, frac_r};
  assign ln_val = prod_r[PRW-1:hll_pkg::LN2_BITS];
  assign est_lin = ({{(64-DW){1'b0}}, ln_val} << keff) >> 32;

  always_ff @(posedge clk) begin
    if (cmd.ln_mul) begin
      prod_r <= PRW'(d_val) * PRW'(hll_pkg::LN2_Q26);
    end
  end

  // result register
  logic        out_valid_r;
  logic [63:0] out_est_r;
  logic        out_lin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_est_r <= cmd.fin_lin ? est_lin : (q_sat ? {64{1'b1}} : q_lo);
      out_lin_r <= cmd.fin_lin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_est   = out_est_r;
  assign out_lin   = out_lin_r;

  always_comb begin
    status.clr_last   = scan_cnt_r == {AW{1'b1}};
    status.sum_last   = scan_cnt_r == mask;
    status.div_last   = dcnt_r == '0;
    status.log_last   = lcnt_r == 5'd0;
    status.lin_needed = !q_sat && (q_lo < lin_thr) && (zeros_r != '0);
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

@@ design/hll_ctrl.sv @@
`timescale 1ns / 1ps
// sequencing state machine of the hyperloglog distinct counter
module hll_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           req_type,
  output logic                 in_ready,
  input  hll_pkg::hll_status_t status,
  output hll_pkg::hll_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_INIT    = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_INS     = 12'b0000_0000_0100,
    S_CLR     = 12'b0000_0000_1000,
    S_SUM     = 12'b0000_0001_0000,
    S_SUM_END = 12'b0000_0010_0000,
    S_DIV     = 12'b0000_0100_0000,
    S_CHK     = 12'b0000_1000_0000,
    S_LOG     = 12'b0001_0000_0000,
    S_LN      = 12'b0010_0000_0000,
    S_FIN_HLL = 12'b0100_0000_0000,
    S_FIN_LIN = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (hll_pkg::hll_req_t'(req_type))
            hll_pkg::REQ_INSERT, hll_pkg::REQ_MERGE: begin
              cmd.ins_load = 1'b1;
              state_nxt    = S_INS;
            end
            hll_pkg::REQ_ESTIMATE: begin
              cmd.sum_start = 1'b1;
              state_nxt     = S_SUM;
            end
            hll_pkg::REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        cmd.ins_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) state_nxt = S_SUM_END;
      end
      S_SUM_END: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.lin_needed) begin
          cmd.log_load = 1'b1;
          state_nxt    = S_LOG;
        end else begin
          state_nxt = S_FIN_HLL;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (status.log_last) state_nxt = S_LN;
      end
      S_LN: begin
        cmd.ln_mul = 1'b1;
        state_nxt  = S_FIN_LIN;
      end
      S_FIN_HLL: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_LIN: begin
        if (status.out_free) begin
          cmd.fin     = 1'b1;
          cmd.fin_lin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the hyperloglog distinct counter
module testbench;
  import hll_pkg::*;

  // one expected estimate result
  typedef struct {
    logic [63:0] estimate;
    logic        linear;
  } est_result_t;

  // sketch predictor and store of expected estimates
  class hll_scoreboard;
    logic [6:0]  rank_mem [0:(1 << MAX_LOG2_COUNTERS_DEF) - 1];
    logic [3:0]  k_reg;
    est_result_t pending_est [$];
    int          mismatches;

    function new();
      k_reg = LOG2_COUNTERS_RST;
      mismatches = 0;
      foreach (rank_mem[i]) rank_mem[i] = '0;
    endfunction

    function void write_k(logic [3:0] v);
      k_reg = v;
    endfunction

    function int unsigned eff_k();
      int unsigned k;
      k = k_reg;
      if (k < MIN_LOG2_COUNTERS) k = MIN_LOG2_COUNTERS;
      if (k > MAX_LOG2_COUNTERS_DEF) k = MAX_LOG2_COUNTERS_DEF;
      return k;
    endfunction

    function logic [63:0] alpha_of(int unsigned k);
      logic [63:0] m, d;
      m = 64'd1 << k;
      if (k == 4) return ((64'd673 << 30) + 64'd500) / 64'd1000;
      if (k == 5) return ((64'd697 << 30) + 64'd500) / 64'd1000;
      if (k == 6) return ((64'd709 << 30) + 64'd500) / 64'd1000;
      d = 64'd10 * (64'd1000 * m + 64'd1079);
      return (((64'd7213 * m) << 30) + d / 2) / d;
    endfunction

    // log2 in q32 by repeated squaring of a q30 mantissa
    function logic [63:0] log2_fix(logic [63:0] v);
      int unsigned p;
      logic [63:0] y, frac;
      p = 0;
      frac = '0;
      while (p < 40 && (v >> (p + 1)) != 0) p++;
      y = (v << 30) >> p;
      for (int i = 0; i < LOG_ITERS; i++) begin
        y = (y * y) >> 30;
        frac = frac << 1;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          frac[0] = 1'b1;
        end
      end
      return (64'(p) << 32) | frac;
    endfunction

    // accepted request transaction: update sketch, maybe queue a result
    function void note_request(hll_req_t req, logic [63:0] h, logic [19:0] midx,
                               logic [6:0] mval);
      int unsigned k, rank;
      logic [63:0] m, idx, zeros, q64, d, ln;
      logic [127:0] zsum, num, q;
      logic [6:0] c;
      est_result_t r;
      k = eff_k();
      m = 64'd1 << k;
      case (req)
        REQ_INSERT: begin
          idx = (h >> HASH_IDX_LSB) & (m - 1);
          if (h == 0) rank = MAX_RANK;
          else begin
            rank = 1;
            while (h[0] == 1'b0) begin
              h = h >> 1;
              rank++;
            end
          end
          if (rank > rank_mem[idx]) rank_mem[idx] = 7'(rank);
        end
        REQ_MERGE: begin
          idx = 64'(midx) & (m - 1);
          c = (mval > MAX_RANK) ? MAX_RANK : mval;
          if (c > rank_mem[idx]) rank_mem[idx] = c;
        end
        REQ_CLEAR: foreach (rank_mem[i]) rank_mem[i] = '0;
        default: begin
          zsum = '0;
          zeros = '0;
          for (int i = 0; i < m; i++) begin
            c = rank_mem[i];
            if (c > MAX_RANK) c = MAX_RANK;
            if (c == 0) zeros++;
            zsum = zsum + (128'd1 << (Z_FRAC_BITS - c));
          end
          num = 128'(alpha_of(k)) << (2 * k + NUM_SHIFT);
          q = num / zsum;
          q64 = q[63:0];
          r.estimate = (q[127:64] != 0) ? '1 : q64;
          r.linear = 1'b0;
          if (q[127:64] == 0 && q64 < (5 * m) / 2 && zeros != 0) begin
            d = (64'(k) << 32) - log2_fix(zeros);
            ln = (d * 64'(LN2_Q26)) >> LN2_BITS;
            r.estimate = (ln * m) >> 32;
            r.linear = 1'b1;
          end
          pending_est.push_back(r);
        end
      endcase
    endfunction

    function void check_result(logic [63:0] est, logic lin);
      est_result_t e;
      if (pending_est.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: estimate %0d linear %0b", est, lin);
        return;
      end
      e = pending_est.pop_front();
      if (est !== e.estimate || lin !== e.linear) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected estimate %0d linear %0b, got %0d linear %0b",
                   e.estimate, e.linear, est, lin);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hll_req_if in_chan ();
  hll_res_if out_chan ();
  hll_cfg_if cfg_chan ();

  hyperloglog_distinct_counter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  hll_scoreboard sketch_sb;

  // idling controls, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned est_pct;

  // clearing pass plus slack, used before a register write
  localparam int DRAIN_CYCLES = (1 << MAX_LOG2_COUNTERS_DEF) + 200;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  initial begin
    #(12ns * 10000000);
    $display("Some tests failed");
    $finish;
  end

  // send one request transaction, then maybe idle
  task automatic send_req(hll_req_t req, logic [63:0] h, logic [19:0] midx,
                          logic [6:0] mval);
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= req;
    in_chan.hash_value  <= h;
    in_chan.merge_index <= midx;
    in_chan.merge_value <= mval;
    do @(posedge clk); while (!in_chan.ready);
    sketch_sb.note_request(req, h, midx, mval);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // register write, only with the block idle
  task automatic write_k(logic [3:0] v);
    in_chan.valid <= 1'b0;
    while (sketch_sb.pending_est.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_chan.valid         <= 1'b1;
    cfg_chan.log2_counters <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    sketch_sb.write_k(v);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hash with a random count of trailing zeros, to spread the ranks
  function automatic logic [63:0] rand_hash();
    logic [63:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return h;
    return h & ('1 << $urandom_range(20));
  endfunction

  task automatic random_req();
    int unsigned r;
    logic [6:0] mval;
    r = $urandom_range(99);
    mval = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(65));
    if (r < est_pct)
      send_req(REQ_ESTIMATE, {$urandom, $urandom}, 20'($urandom), mval);
    else if (r < est_pct + 2)
      send_req(REQ_CLEAR, {$urandom, $urandom}, 20'($urandom), mval);
    else if (r < est_pct + 20)
      send_req(REQ_MERGE, {$urandom, $urandom}, 20'($urandom), mval);
    else
      send_req(REQ_INSERT, rand_hash(), 20'($urandom), mval);
  endtask

  // result side: check each transaction, stall at random or hold off
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready)
        sketch_sb.check_result(out_chan.estimate, out_chan.used_linear_counting);
      if (hold_req) begin
        // long hold-off so the output register and then the input back up
        out_chan.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    logic [3:0] phase_k [8];
    sketch_sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    est_pct = 12;
    in_chan.valid          <= 1'b0;
    in_chan.req_type       <= REQ_INSERT;
    in_chan.hash_value     <= '0;
    in_chan.merge_index    <= '0;
    in_chan.merge_value    <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.log2_counters <= LOG2_COUNTERS_RST;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at 16 counters
    write_k(4'd4);
    send_req(REQ_ESTIMATE, '0, '0, '0);            // empty sketch
    send_req(REQ_INSERT, '0, '0, '0);              // hash of zero, top rank
    send_req(REQ_INSERT, '1, '1, '1);              // all ones, rank one
    send_req(REQ_INSERT, 64'h8000_0000_0000_0000, '0, '0);
    send_req(REQ_MERGE, '0, 20'hFFFFF, 7'd127);    // saturated merge, wrapped index
    send_req(REQ_ESTIMATE, '0, '0, '0);
    // fill every counter to the top rank: quotient overflows
    for (int i = 0; i < 16; i++) send_req(REQ_MERGE, '0, 20'(i), 7'd65);
    send_req(REQ_ESTIMATE, '0, '0, '0);
    send_req(REQ_CLEAR, '1, '0, '0);
    send_req(REQ_ESTIMATE, '0, '0, '0);

    // pressure: receiver holds off while estimates and inserts keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_req(REQ_ESTIMATE, '0, '0, '0);
      send_req(REQ_INSERT, rand_hash(), '0, '0);
    end
    // sender pause until the sketch has drained every result
    in_chan.valid <= 1'b0;
    while (sketch_sb.pending_est.size() != 0 || hold_req) @(posedge clk);

    // random phases across register settings, out-of-range ones included
    phase_k = '{4'd4, 4'd0, 4'd15, 4'd7, 4'd5, 4'd6, 4'd10, 4'd3};
    for (int p = 0; p < 8; p++) begin
      write_k(phase_k[p]);
      est_pct = (sketch_sb.eff_k() >= 12) ? 3 : 12;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int i = 0; i < 94; i++) random_req();
      send_req(REQ_ESTIMATE, '0, '0, '0);
    end
    in_chan.valid <= 1'b0;

    while (sketch_sb.pending_est.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sketch_sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
